### design/sled_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sled_pkg - shared types and constants for the string literal escape decoder
// Item layout between the classifier and the decode engine, decode modes and
// code point constants.
// ----------------------------------------------------------------------------
package sled_pkg;

  localparam int CODE_W          = 21;
  localparam int CHAR_W          = 32;
  localparam int HEX_W           = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Named escape targets and escape syntax characters
  localparam logic [CODE_W-1:0] CH_QUOTE  = 21'h22;
  localparam logic [CODE_W-1:0] CH_BSLASH = 21'h5c;
  localparam logic [CODE_W-1:0] CH_SEMI   = 21'h3b;
  localparam logic [CODE_W-1:0] CH_X      = 21'h78;
  localparam logic [CODE_W-1:0] CH_BEL    = 21'h07;
  localparam logic [CODE_W-1:0] CH_BS     = 21'h08;
  localparam logic [CODE_W-1:0] CH_TAB    = 21'h09;
  localparam logic [CODE_W-1:0] CH_LF     = 21'h0a;
  localparam logic [CODE_W-1:0] CH_VT     = 21'h0b;
  localparam logic [CODE_W-1:0] CH_FF     = 21'h0c;
  localparam logic [CODE_W-1:0] CH_CR     = 21'h0d;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2,
    MODE_SKIP   = 2'd3
  } mode_t;

  // One classified code point
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
    logic              is_bslash;
    logic              is_x;
    logic              is_semi;
    logic              is_space;
    logic              is_hex;
    logic [HEX_W-1:0]  hex_val;
    logic              is_named;
    logic [6:0]        named_val;
  } item_t;

endpackage : sled_pkg
`default_nettype wire

### design/sled_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sled_front - input classifier
// Takes code points off the input channel and tags each one with its
// character classes before it enters the queue.
// ----------------------------------------------------------------------------
module sled_front
  import sled_pkg::*;
(
  input  wire logic [CODE_W-1:0] in_code_point,
  input  wire logic              in_last_char,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic              q_full,
  output logic                   q_push,
  output item_t                  q_item
);

  localparam logic [CODE_W-1:0] CH_NEL      = 21'h85;
  localparam logic [CODE_W-1:0] CH_SP       = 21'h20;
  localparam logic [CODE_W-1:0] CH_NBSP     = 21'ha0;
  localparam logic [CODE_W-1:0] CH_OGHAM    = 21'h1680;
  localparam logic [CODE_W-1:0] CH_MVS      = 21'h180e;
  localparam logic [CODE_W-1:0] CH_EN_QUAD  = 21'h2000;
  localparam logic [CODE_W-1:0] CH_HAIR     = 21'h200a;
  localparam logic [CODE_W-1:0] CH_LSEP     = 21'h2028;
  localparam logic [CODE_W-1:0] CH_NNBSP    = 21'h202f;
  localparam logic [CODE_W-1:0] CH_MMSP     = 21'h205f;
  localparam logic [CODE_W-1:0] CH_IDEO_SP  = 21'h3000;

  logic [CODE_W-1:0] c;

  assign c       = in_code_point;
  assign in_full = q_full;
  assign q_push  = in_push & ~q_full;

  always_comb begin
    q_item           = '0;
    q_item.code      = c;
    q_item.last      = in_last_char;
    q_item.is_bslash = (c == CH_BSLASH);
    q_item.is_x      = (c == CH_X);
    q_item.is_semi   = (c == CH_SEMI);

    unique case (c) inside
      CH_CR, CH_LF, CH_NEL, CH_LSEP, CH_TAB, CH_SP, CH_NBSP, CH_OGHAM, CH_MVS,
      [CH_EN_QUAD:CH_HAIR], CH_NNBSP, CH_MMSP, CH_IDEO_SP: q_item.is_space = 1'b1;
      default:                                            q_item.is_space = 1'b0;
    endcase

    // hex digit value
    if (c >= 21'h30 && c <= 21'h39) begin
      q_item.is_hex  = 1'b1;
      q_item.hex_val = c[HEX_W-1:0];
    end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
      q_item.is_hex  = 1'b1;
      q_item.hex_val = HEX_W'(c[HEX_W-1:0] + 4'd9);
    end

    q_item.is_named = 1'b1;
    unique case (c)
      CH_QUOTE:  q_item.named_val = CH_QUOTE[6:0];
      CH_BSLASH: q_item.named_val = CH_BSLASH[6:0];
      21'h61:    q_item.named_val = CH_BEL[6:0];
      21'h62:    q_item.named_val = CH_BS[6:0];
      21'h74:    q_item.named_val = CH_TAB[6:0];
      21'h6e:    q_item.named_val = CH_LF[6:0];
      21'h76:    q_item.named_val = CH_VT[6:0];
      21'h66:    q_item.named_val = CH_FF[6:0];
      21'h72:    q_item.named_val = CH_CR[6:0];
      default: begin
        q_item.is_named  = 1'b0;
        q_item.named_val = '0;
      end
    endcase
  end

endmodule : sled_front
`default_nettype wire

### design/sled_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sled_queue - short FIFO of classified items
// Decouples the classifier from the decode engine.
// ----------------------------------------------------------------------------
module sled_queue
  import sled_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  item_t     wdata,
  output logic      full,
  input  wire logic pop,
  output item_t     rdata,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : AW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : AW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule : sled_queue
`default_nettype wire

### design/sled_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sled_back - escape decode engine
// Runs the decode mode machine on classified items and holds the result in
// an output register until it is popped.
// ----------------------------------------------------------------------------
module sled_back
  import sled_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  item_t                   q_item,
  output logic                    q_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic                    out_has_char,
  output logic [CHAR_W-1:0]       out_decoded_char,
  output logic                    out_end_of_literal
);

  mode_t             mode_r, mode_nxt;
  logic [CHAR_W-1:0] acc_r, acc_nxt;
  logic              valid_r, valid_nxt;
  logic              has_r, has_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              end_r, end_nxt;
  logic              fire;
  logic [CHAR_W-1:0] code_ext;

  assign fire     = ~q_empty & (~valid_r | out_pop);
  assign q_pop    = fire;
  assign code_ext = CHAR_W'(q_item.code);

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    valid_nxt = valid_r & ~out_pop;
    has_nxt   = has_r;
    char_nxt  = char_r;
    end_nxt   = end_r;
    if (fire) begin
      logic              has;
      logic [CHAR_W-1:0] ch;
      has      = 1'b0;
      ch       = '0;
      mode_nxt = MODE_NORMAL;
      unique case (mode_r)
        MODE_ESCAPE: begin
          if (q_item.is_named) begin
            has = 1'b1;
            ch  = CHAR_W'(q_item.named_val);
          end else if (q_item.is_x) begin
            mode_nxt = MODE_HEX;
            acc_nxt  = '0;
          end else if (q_item.is_space) begin
            mode_nxt = MODE_SKIP;
          end else begin
            has = 1'b1;
            ch  = code_ext;
          end
        end
        MODE_HEX: begin
          if (q_item.is_semi) begin
            has = 1'b1;
            ch  = acc_r;
          end else if (q_item.is_hex) begin
            mode_nxt = MODE_HEX;
            acc_nxt  = {acc_r[CHAR_W-HEX_W-1:0], q_item.hex_val};
          end
        end
        MODE_SKIP: begin
          if (q_item.is_space) begin
            mode_nxt = MODE_SKIP;
          end else if (q_item.is_bslash) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            has = 1'b1;
            ch  = code_ext;
          end
        end
        default: begin
          if (q_item.is_bslash) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            has = 1'b1;
            ch  = code_ext;
          end
        end
      endcase
      // end of literal drops any open escape
      if (q_item.last) begin
        mode_nxt = MODE_NORMAL;
        acc_nxt  = '0;
      end
      valid_nxt = 1'b1;
      has_nxt   = has;
      char_nxt  = ch;
      end_nxt   = q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      acc_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    has_r  <= has_nxt;
    char_r <= char_nxt;
    end_r  <= end_nxt;
  end

  assign out_empty          = ~valid_r;
  assign out_has_char       = has_r;
  assign out_decoded_char   = char_r;
  assign out_end_of_literal = end_r;

endmodule : sled_back
`default_nettype wire

### design/string_literal_escape_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_top - string literal escape decoder
// Turns the code points of a literal body into decoded code points,
// resolving named, hex and whitespace-skip escapes.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive in_code_point / in_last_char and raise
//   in_push; the transaction completes on a clock edge with in_full low.
//   Result side is a queue too: while out_empty is low the oldest result
//   sits on out_has_char / out_decoded_char / out_end_of_literal, and it
//   leaves on a clock edge with out_pop high.
//   Every input transaction yields exactly one result transaction, with
//   out_has_char low (and out_decoded_char zero) when nothing is emitted.
//   An accepted input is written into the item queue, and the decode
//   engine then pops it and registers the result in the output register.
//   Throughput: one transaction per cycle while the receiver keeps popping,
//   set by the decode mode machine in the back end.
//   When the receiver stalls, the output register holds and the item queue
//   (QUEUE_DEPTH entries) fills; in_full rises once it is full.
//   Synchronous reset (rst_n low) empties the queue and output register and
//   returns the decoder to normal mode with a zero hex accumulator.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_top
  import sled_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CODE_W-1:0] in_code_point,
  input  wire logic              in_last_char,
  input  wire logic              in_push,
  output logic                   in_full,
  output logic                   out_has_char,
  output logic [CHAR_W-1:0]      out_decoded_char,
  output logic                   out_end_of_literal,
  output logic                   out_empty,
  input  wire logic              out_pop
);

  // classifier -> queue
  item_t front_item;
  logic  q_push;
  logic  q_full;
  // queue -> decode engine
  item_t q_item;
  logic  q_empty;
  logic  q_pop;

  sled_front u_front (
    .in_code_point (in_code_point),
    .in_last_char  (in_last_char),
    .in_push       (in_push),
    .in_full       (in_full),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (front_item)
  );

  sled_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (front_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  sled_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_has_char       (out_has_char),
    .out_decoded_char   (out_decoded_char),
    .out_end_of_literal (out_end_of_literal)
  );

  // Reset leaves both sides empty and ready
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queue or output not cleared by reset");

  // Decode engine only consumes real items
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("decode engine popped an empty queue");

  // A result without a character carries a zero code point
  a_no_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_has_char) |-> (out_decoded_char == '0))
    else $error("nonzero code point on a result without a character");

  // A full output that is not popped holds its result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_decoded_char)))
    else $error("stalled result changed");

endmodule : string_literal_escape_decoder_top
`default_nettype wire

### bench/sled_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sled_decode_checker - result checker for the string literal escape decoder
// Watches both queue ports, predicts the decoded code point of every input
// transaction and compares each result transaction against the oldest one.
// ----------------------------------------------------------------------------
module sled_decode_checker
  import sled_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CODE_W-1:0] in_code_point,
  input  wire logic              in_last_char,
  input  wire logic              in_push,
  input  wire logic              in_full,
  input  wire logic              out_has_char,
  input  wire logic [CHAR_W-1:0] out_decoded_char,
  input  wire logic              out_end_of_literal,
  input  wire logic              out_empty,
  input  wire logic              out_pop,
  output int                     fail_count,
  output int                     pending
);

  // Escape letters
  localparam logic [CODE_W-1:0] LTR_A = 21'h61;
  localparam logic [CODE_W-1:0] LTR_B = 21'h62;
  localparam logic [CODE_W-1:0] LTR_T = 21'h74;
  localparam logic [CODE_W-1:0] LTR_N = 21'h6e;
  localparam logic [CODE_W-1:0] LTR_V = 21'h76;
  localparam logic [CODE_W-1:0] LTR_F = 21'h66;
  localparam logic [CODE_W-1:0] LTR_R = 21'h72;

  // Whitespace beyond CR, LF and tab
  localparam logic [CODE_W-1:0] CP_NEL    = 21'h85;
  localparam logic [CODE_W-1:0] CP_LSEP   = 21'h2028;
  localparam logic [CODE_W-1:0] CP_SPACE  = 21'h20;
  localparam logic [CODE_W-1:0] CP_NBSP   = 21'ha0;
  localparam logic [CODE_W-1:0] CP_OGHAM  = 21'h1680;
  localparam logic [CODE_W-1:0] CP_MVS    = 21'h180e;
  localparam logic [CODE_W-1:0] CP_ENQUAD = 21'h2000;
  localparam logic [CODE_W-1:0] CP_HAIRSP = 21'h200a;
  localparam logic [CODE_W-1:0] CP_NNBSP  = 21'h202f;
  localparam logic [CODE_W-1:0] CP_MMSP   = 21'h205f;
  localparam logic [CODE_W-1:0] CP_IDSP   = 21'h3000;

  typedef struct packed {
    logic              has;
    logic [CHAR_W-1:0] ch;
    logic              eol;
  } decoded_t;

  mode_t             mode;
  logic [CHAR_W-1:0] hex_acc;
  decoded_t          decoded_q[$];

  function automatic logic is_ws(input logic [CODE_W-1:0] c);
    return c == CH_CR || c == CH_LF || c == CP_NEL || c == CP_LSEP ||
           c == CH_TAB || c == CP_SPACE || c == CP_NBSP || c == CP_OGHAM ||
           c == CP_MVS || (c >= CP_ENQUAD && c <= CP_HAIRSP) ||
           c == CP_NNBSP || c == CP_MMSP || c == CP_IDSP;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [CODE_W-1:0] c);
    if (c >= 21'h30 && c <= 21'h39) return {1'b1, c[3:0]};
    if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46))
      return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // Normal-mode character: backslash opens an escape, all else is emitted
  function automatic void take_plain(input logic [CODE_W-1:0] c, inout decoded_t r);
    if (c == CH_BSLASH) begin
      mode = MODE_ESCAPE;
    end else begin
      mode = MODE_NORMAL;
      r.has = 1'b1;
      r.ch = CHAR_W'(c);
    end
  endfunction

  function automatic decoded_t decode_char(input logic [CODE_W-1:0] c, input logic last);
    decoded_t   r;
    logic [4:0] nib;
    r = '{has: 1'b0, ch: '0, eol: last};
    nib = hex_nibble(c);
    case (mode)
      MODE_ESCAPE: begin
        mode = MODE_NORMAL;
        r.has = 1'b1;
        case (c)
          CH_QUOTE:  r.ch = CHAR_W'(CH_QUOTE);
          CH_BSLASH: r.ch = CHAR_W'(CH_BSLASH);
          LTR_A:     r.ch = CHAR_W'(CH_BEL);
          LTR_B:     r.ch = CHAR_W'(CH_BS);
          LTR_T:     r.ch = CHAR_W'(CH_TAB);
          LTR_N:     r.ch = CHAR_W'(CH_LF);
          LTR_V:     r.ch = CHAR_W'(CH_VT);
          LTR_F:     r.ch = CHAR_W'(CH_FF);
          LTR_R:     r.ch = CHAR_W'(CH_CR);
          CH_X: begin
            r.has = 1'b0;
            mode = MODE_HEX;
            hex_acc = '0;
          end
          default: begin
            if (is_ws(c)) begin
              r.has = 1'b0;
              mode = MODE_SKIP;
            end else begin
              r.ch = CHAR_W'(c);
            end
          end
        endcase
      end
      MODE_HEX: begin
        if (c == CH_SEMI) begin
          r.has = 1'b1;
          r.ch = hex_acc;
          mode = MODE_NORMAL;
        end else if (nib[4]) begin
          hex_acc = {hex_acc[CHAR_W-5:0], nib[3:0]};
        end else begin
          mode = MODE_NORMAL;
        end
      end
      MODE_SKIP: begin
        if (!is_ws(c)) take_plain(c, r);
      end
      default: take_plain(c, r);
    endcase
    if (last) begin
      mode = MODE_NORMAL;
      hex_acc = '0;
    end
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [CHAR_W-1:0] want,
                                      input logic [CHAR_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    decoded_t want;
    if (!rst_n) begin
      mode = MODE_NORMAL;
      hex_acc = '0;
      decoded_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, expected nothing, actual %b/%h/%b",
                   $time, out_has_char, out_decoded_char, out_end_of_literal);
        end else begin
          want = decoded_q.pop_front();
          check_field("has_char", CHAR_W'(want.has), CHAR_W'(out_has_char));
          check_field("decoded_char", want.ch, out_decoded_char);
          check_field("end_of_literal", CHAR_W'(want.eol), CHAR_W'(out_end_of_literal));
        end
      end
      if (in_push && !in_full) decoded_q.push_back(decode_char(in_code_point, in_last_char));
    end
    pending = decoded_q.size();
  end

endmodule : sled_decode_checker

### bench/tb_string_literal_escape_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_string_literal_escape_decoder_top - testbench for the escape decoder
// Feeds literal bodies built from plain text, named, hex and whitespace
// escapes plus noise, under several idle and stall mixes, and lets the
// checker compare every result transaction with its prediction.
// ----------------------------------------------------------------------------
module tb_string_literal_escape_decoder_top
  import sled_pkg::*;
();

  localparam int QUIET_LIMIT = 4000;   // cycles with no transaction at all
  localparam int HOLD_CYCLES = 80;     // long receiver hold-off

  typedef struct packed {
    logic [CODE_W-1:0] cp;
    logic              last;
  } lit_char_t;

  logic              clk;
  logic              rst_n;
  logic [CODE_W-1:0] in_code_point;
  logic              in_last_char;
  logic              in_push;
  logic              in_full;
  logic              out_has_char;
  logic [CHAR_W-1:0] out_decoded_char;
  logic              out_end_of_literal;
  logic              out_empty;
  logic              out_pop;

  int fail_count;
  int pending;
  int items_sent;
  int idle_pct;       // sender idle chance, percent per cycle
  int stall_pct;      // receiver stall chance, percent per cycle
  int hold_reqs;      // bumped to ask the receiver for a long hold-off
  int quiet_cycles;
  lit_char_t lit_q[$];

  string_literal_escape_decoder_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_code_point     (in_code_point),
    .in_last_char      (in_last_char),
    .in_push           (in_push),
    .in_full           (in_full),
    .out_has_char      (out_has_char),
    .out_decoded_char  (out_decoded_char),
    .out_end_of_literal(out_end_of_literal),
    .out_empty         (out_empty),
    .out_pop           (out_pop)
  );

  sled_decode_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_code_point     (in_code_point),
    .in_last_char      (in_last_char),
    .in_push           (in_push),
    .in_full           (in_full),
    .out_has_char      (out_has_char),
    .out_decoded_char  (out_decoded_char),
    .out_end_of_literal(out_end_of_literal),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: any accepted transaction on either side counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random pops at stall_pct, plus a long hold-off whenever the
  // stimulus side bumps hold_reqs. The hold is counted here, not by the sender.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // One input transaction. Called right after a rising edge; returns right
  // after the edge that accepted it. in_full is sampled at the falling edge,
  // where it already holds the value the next rising edge will see.
  task automatic send_char(input logic [CODE_W-1:0] cp, input logic last);
    logic was_full;
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_code_point <= cp;
    in_last_char  <= last;
    do begin
      @(negedge clk);
      was_full = in_full;
      @(posedge clk);
    end while (was_full);
    items_sent++;
  endtask

  // Whitespace set used by the skip escape, including the whole 0x2000 to 0x200a range
  function automatic logic [CODE_W-1:0] pick_ws();
    case ($urandom_range(13))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return 21'h85;
      3:       return 21'h2028;
      4:       return CH_TAB;
      5:       return 21'h20;
      6:       return 21'ha0;
      7:       return 21'h1680;
      8:       return 21'h180e;
      9:       return 21'h202f;
      10:      return 21'h205f;
      11:      return 21'h3000;
      default: return 21'h2000 + CODE_W'($urandom_range(10));
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_named();
    case ($urandom_range(8))
      0:       return CODE_W'("\"");
      1:       return CODE_W'("\\");
      2:       return CODE_W'("a");
      3:       return CODE_W'("b");
      4:       return CODE_W'("t");
      5:       return CODE_W'("n");
      6:       return CODE_W'("v");
      7:       return CODE_W'("f");
      default: return CODE_W'("r");
    endcase
  endfunction

  // Hex digit in either case
  function automatic logic [CODE_W-1:0] pick_hex_digit();
    int d;
    d = $urandom_range(15);
    if (d < 10) return 21'h30 + CODE_W'(d);
    return ($urandom_range(1) ? 21'h61 : 21'h41) + CODE_W'(d - 10);
  endfunction

  // Mix of printable text, whitespace, neighbors of the whitespace ranges,
  // hex digits and the full code point range.
  function automatic logic [CODE_W-1:0] pick_cp();
    case ($urandom_range(9))
      0, 1, 2, 3: return CODE_W'($urandom_range(8'h7e, 8'h20));
      4, 5:       return pick_ws();
      6:          return CODE_W'($urandom_range(21'h10ffff));
      7: begin
        case ($urandom_range(3))
          0:       return CODE_W'($urandom_range(21'h200b, 21'h1fff));
          1:       return CODE_W'($urandom_range(21'h2060, 21'h205e));
          2:       return CODE_W'($urandom_range(21'ha1, 21'h84));
          default: return CODE_W'($urandom_range(21'h3001, 21'h2fff));
        endcase
      end
      8:          return pick_hex_digit();
      default:    return 21'h10ffff - CODE_W'($urandom_range(3));
    endcase
  endfunction

  function automatic void add_char(input logic [CODE_W-1:0] cp);
    lit_q.push_back('{cp: cp, last: 1'b0});
  endfunction

  // One piece of a literal body: mostly well-formed escapes, some noise
  function automatic void add_fragment();
    int n;
    case ($urandom_range(9))
      0, 1: add_char(pick_cp());
      2: begin
        add_char(CODE_W'("\\"));
        add_char(pick_named());
      end
      3, 4: begin
        add_char(CODE_W'("\\"));
        add_char(CODE_W'("x"));
        n = $urandom_range(10);       // zero to ten digits, so zero or more than eight
        repeat (n) add_char(pick_hex_digit());
        case ($urandom_range(9))
          8:       add_char(pick_cp());   // usually a bad digit
          9:       ;                      // left open
          default: add_char(CODE_W'(";"));
        endcase
      end
      5, 6: begin
        add_char(CODE_W'("\\"));
        n = $urandom_range(4, 1);
        repeat (n) add_char(pick_ws());
        if ($urandom_range(1)) add_char(pick_cp());
      end
      7: begin
        add_char(CODE_W'("\\"));
        add_char(pick_cp());
      end
      8: begin
        n = $urandom_range(3, 1);
        repeat (n) add_char(CODE_W'($urandom_range(21'h10ffff)));
      end
      default: add_char(CODE_W'("\\"));
    endcase
  endfunction

  // Build and send one literal; sometimes cut short so that the last
  // character lands inside an escape.
  task automatic send_literal();
    int nfrag;
    int keep;
    lit_q.delete();
    nfrag = $urandom_range(8, 1);
    repeat (nfrag) add_fragment();
    if ($urandom_range(4) == 0) begin
      keep = $urandom_range(lit_q.size(), 1);
      while (lit_q.size() > keep) void'(lit_q.pop_back());
    end
    lit_q[lit_q.size() - 1].last = 1'b1;
    foreach (lit_q[i]) send_char(lit_q[i].cp, lit_q[i].last);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n_items);
    int target;
    idle_pct = idle;
    stall_pct <= stall;
    target = items_sent + n_items;
    while (items_sent < target) send_literal();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_code_point = '0;
    in_last_char  = 1'b0;
    items_sent    = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_reqs     = 0;
    quiet_cycles  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes and each escape flavor
    send_char(CODE_W'("A"), 1'b0);
    send_char(21'h10ffff, 1'b1);
    send_char(CODE_W'("\\"), 1'b0);   // escaped quote
    send_char(CODE_W'("\""), 1'b0);
    send_char(CODE_W'("\\"), 1'b0);   // escaped backslash
    send_char(CODE_W'("\\"), 1'b0);
    send_char(CODE_W'("\\"), 1'b0);   // newline escape
    send_char(CODE_W'("n"), 1'b0);
    send_char(CODE_W'("\\"), 1'b0);   // hex escape, mixed case
    send_char(CODE_W'("x"), 1'b0);
    send_char(CODE_W'("F"), 1'b0);
    send_char(CODE_W'("f"), 1'b0);
    send_char(CODE_W'(";"), 1'b0);
    send_char(CODE_W'("\\"), 1'b0);   // empty hex escape
    send_char(CODE_W'("x"), 1'b0);
    send_char(CODE_W'(";"), 1'b0);
    send_char(CODE_W'("\\"), 1'b0);   // bad hex digit drops the escape
    send_char(CODE_W'("x"), 1'b0);
    send_char(CODE_W'("g"), 1'b0);
    send_char(CODE_W'("\\"), 1'b0);   // whitespace skip, then plain char
    send_char(21'h3000, 1'b0);
    send_char(21'h20, 1'b0);
    send_char(CODE_W'("q"), 1'b0);
    send_char(CODE_W'("\\"), 1'b0);   // other escaped char
    send_char(CODE_W'("z"), 1'b0);
    send_char(CODE_W'("\\"), 1'b1);   // literal ends inside an escape

    // Random literals under each idle/stall mix
    run_phase(0, 0, 330);
    run_phase(51, 0, 330);
    run_phase(0, 51, 330);
    run_phase(31, 31, 330);

    // Receiver holds off while the sender keeps pushing: queue fills, in_full rises
    idle_pct = 0;
    stall_pct <= 0;
    hold_reqs <= hold_reqs + 1;
    while (items_sent < 1450) send_literal();

    run_phase(0, 0, 200);
    in_push <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule : tb_string_literal_escape_decoder_top
